// ----- rtl/core/gha_pkg.sv -----
package gha_pkg;

  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int KIND_W     = 4;
  localparam int DOM_W      = 16;
  localparam int SLOT_W     = 10;
  localparam int GEN_W      = 24;
  localparam int LIVE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [STAT_W-1:0]    status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cmd_t CMD_ALLOC   = 2'd0;
  localparam cmd_t CMD_RELEASE = 2'd1;
  localparam cmd_t CMD_QUERY   = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_REJECT    = 2'd1;
  localparam status_t ST_DISABLED  = 2'd2;
  localparam status_t ST_EXHAUSTED = 2'd3;

  localparam cfg_idx_t CFG_POOL_KIND   = 2'd0;
  localparam cfg_idx_t CFG_POOL_DOMAIN = 2'd1;
  localparam cfg_idx_t CFG_FIRST_GEN   = 2'd2;

endpackage

// ----- rtl/core/gha_slot_mem.sv -----
module gha_slot_mem #(
  parameter int unsigned ENTRIES = 1024,
  parameter int unsigned DW      = 26,
  localparam int unsigned AW     = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/gha_free_stack.sv -----
module gha_free_stack #(
  parameter int unsigned ENTRIES = 1024,
  parameter int unsigned DW      = 34,
  localparam int unsigned AW     = $clog2(ENTRIES),
  localparam int unsigned CW     = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  output logic [DW-1:0] top_data,
  output logic          not_empty,
  output logic          not_full,
  input  logic          pop,
  input  logic          push,
  input  logic [DW-1:0] push_data
);

  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] top_data_r;
  logic [CW-1:0] depth_r;
  logic [CW-1:0] depth_nxt;
  logic [CW-1:0] top_idx;

  assign top_idx   = depth_r - CW'(1);
  assign not_empty = (depth_r != '0);
  assign not_full  = (depth_r != CW'(ENTRIES));

  always_comb begin
    depth_nxt = depth_r;
    if (pop && not_empty) begin
      depth_nxt = depth_r - CW'(1);
    end else if (push && not_full) begin
      depth_nxt = depth_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && not_full && !pop) begin
      mem[depth_r[AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en && not_empty) begin
      top_data_r <= mem[top_idx[AW-1:0]];
    end
  end

  assign top_data = top_data_r;

endmodule

// ----- rtl/core/generational_handle_allocator.sv -----
// Channel   Handshake                     Payload
// input     start & !busy                 in_cmd, in_handle_*
// result    out_valid (one-cycle strobe)  out_status, out_new_*, out_live_total
// config    cfg_valid & cfg_ready         cfg_index, cfg_data
//
// In each transaction the accept edge issues the slot-table and free-stack
// reads, and the next edge does the read-modify-write and loads the result
// register, so out_valid is high for the cycle after that edge.
// busy is high from the accept edge to the read-modify-write edge, so a new
// transaction cannot start until the current one is through that edge.
// Reset is synchronous, active low; the slot table needs no clearing pass.
// The receiver cannot stall; cfg_ready is always high.
module generational_handle_allocator #(
  parameter int unsigned     SLOT_COUNT = 1024,
  parameter longint unsigned GEN_MAX    = 16777215
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  gha_pkg::cmd_t                   in_cmd,
  input  logic                            in_handle_valid,
  input  logic [gha_pkg::KIND_W-1:0]      in_handle_kind,
  input  logic [gha_pkg::DOM_W-1:0]       in_handle_domain,
  input  logic [gha_pkg::SLOT_W-1:0]      in_handle_slot,
  input  logic [gha_pkg::GEN_W-1:0]       in_handle_generation,
  output logic                            out_valid,
  output gha_pkg::status_t                out_status,
  output logic [gha_pkg::KIND_W-1:0]      out_new_kind,
  output logic [gha_pkg::DOM_W-1:0]       out_new_domain,
  output logic [gha_pkg::SLOT_W-1:0]      out_new_slot,
  output logic [gha_pkg::GEN_W-1:0]       out_new_generation,
  output logic [gha_pkg::LIVE_W-1:0]      out_live_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  gha_pkg::cfg_idx_t               cfg_index,
  input  logic [gha_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned SW  = $clog2(SLOT_COUNT);
  localparam int unsigned CW  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned GW  = $clog2(GEN_MAX + 64'd1);
  localparam int unsigned XW  = (GW > gha_pkg::GEN_W) ? GW : gha_pkg::GEN_W;
  localparam int unsigned MW  = GW + 2;
  localparam int unsigned FW  = SW + GW;

  // configuration
  logic [gha_pkg::KIND_W-1:0] pool_kind_r;
  logic [gha_pkg::DOM_W-1:0]  pool_domain_r;
  logic [gha_pkg::GEN_W-1:0]  first_gen_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_kind_r   <= '0;
      pool_domain_r <= gha_pkg::DOM_W'(1);
      first_gen_r   <= gha_pkg::GEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gha_pkg::CFG_POOL_KIND:   pool_kind_r   <= cfg_data[gha_pkg::KIND_W-1:0];
        gha_pkg::CFG_POOL_DOMAIN: pool_domain_r <= cfg_data[gha_pkg::DOM_W-1:0];
        gha_pkg::CFG_FIRST_GEN:   first_gen_r   <= cfg_data[gha_pkg::GEN_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  logic                        accept;
  logic                        busy_r;
  gha_pkg::cmd_t               cmd_r;
  logic                        hvalid_r;
  logic [gha_pkg::KIND_W-1:0]  hkind_r;
  logic [gha_pkg::DOM_W-1:0]   hdomain_r;
  logic [gha_pkg::SLOT_W-1:0]  hslot_r;
  logic [gha_pkg::GEN_W-1:0]   hgen_r;
  logic [31:0]                 in_slot_ext;
  logic [31:0]                 hslot_ext;

  assign accept      = start && !busy_r;
  assign busy        = busy_r;
  assign in_slot_ext = 32'(in_handle_slot);
  assign hslot_ext   = 32'(hslot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_cmd;
      hvalid_r  <= in_handle_valid;
      hkind_r   <= in_handle_kind;
      hdomain_r <= in_handle_domain;
      hslot_r   <= in_handle_slot;
      hgen_r    <= in_handle_generation;
    end
  end

  // slot table: {retired, live, generation}
  logic          sm_we;
  logic [SW-1:0] sm_waddr;
  logic [MW-1:0] sm_wdata;
  logic [MW-1:0] sm_rdata;

  gha_slot_mem #(
    .ENTRIES (SLOT_COUNT),
    .DW      (MW)
  ) u_slot_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_slot_ext[SW-1:0]),
    .rd_data (sm_rdata),
    .wr_en   (sm_we),
    .wr_addr (sm_waddr),
    .wr_data (sm_wdata)
  );

  // free stack: {slot, generation}
  logic          stk_pop;
  logic          stk_push;
  logic [FW-1:0] stk_wdata;
  logic [FW-1:0] stk_top;
  logic          stk_not_empty;
  logic          stk_not_full;

  gha_free_stack #(
    .ENTRIES (SLOT_COUNT),
    .DW      (FW)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .top_data  (stk_top),
    .not_empty (stk_not_empty),
    .not_full  (stk_not_full),
    .pop       (stk_pop),
    .push      (stk_push),
    .push_data (stk_wdata)
  );

  // read-modify-write
  logic [CW-1:0]              use_r;
  logic [CW-1:0]              use_nxt;
  logic [CW-1:0]              live_r;
  logic [CW-1:0]              live_nxt;
  gha_pkg::status_t           status_nxt;
  logic [gha_pkg::KIND_W-1:0] kind_nxt;
  logic [gha_pkg::DOM_W-1:0]  domain_nxt;
  logic [SW-1:0]              slot_nxt;
  logic [GW-1:0]              gen_nxt;

  logic          enabled;
  logic          hit;
  logic          row_live;
  logic          row_retired;
  logic [GW-1:0] row_gen;
  logic [GW-1:0] row_gen_inc;
  logic          row_at_max;
  logic [GW-1:0] first_gen_gw;
  logic [SW-1:0] hslot_sw;
  logic [SW-1:0] stk_slot;
  logic [GW-1:0] stk_gen;
  logic [63:0]   first_gen_ext;

  assign first_gen_ext = 64'(first_gen_r);
  assign first_gen_gw  = first_gen_ext[GW-1:0];
  assign enabled       = (pool_kind_r != '0) && (first_gen_r != '0) &&
                         (first_gen_ext <= GEN_MAX);

  assign row_retired = sm_rdata[MW-1];
  assign row_live    = sm_rdata[MW-2];
  assign row_gen     = sm_rdata[GW-1:0];
  assign row_gen_inc = row_gen + GW'(1);
  assign row_at_max  = (64'(row_gen) >= GEN_MAX);
  assign hslot_sw    = hslot_ext[SW-1:0];
  assign stk_slot    = stk_top[FW-1:GW];
  assign stk_gen     = stk_top[GW-1:0];

  assign hit = hvalid_r && (hkind_r == pool_kind_r) && (hdomain_r == pool_domain_r) &&
               (hslot_ext < 32'(use_r)) && row_live && !row_retired &&
               (XW'(row_gen) == XW'(hgen_r));

  always_comb begin
    status_nxt = gha_pkg::ST_REJECT;
    kind_nxt   = '0;
    domain_nxt = '0;
    slot_nxt   = '0;
    gen_nxt    = '0;
    use_nxt    = use_r;
    live_nxt   = live_r;
    sm_we      = 1'b0;
    sm_waddr   = hslot_sw;
    sm_wdata   = '0;
    stk_pop    = 1'b0;
    stk_push   = 1'b0;
    stk_wdata  = {hslot_sw, row_gen_inc};
    if (busy_r) begin
      if (!enabled) begin
        status_nxt = gha_pkg::ST_DISABLED;
      end else begin
        case (cmd_r)
          gha_pkg::CMD_ALLOC: begin
            if (stk_not_empty) begin
              stk_pop    = 1'b1;
              slot_nxt   = stk_slot;
              gen_nxt    = stk_gen;
              status_nxt = gha_pkg::ST_OK;
            end else if (use_r != CW'(SLOT_COUNT)) begin
              use_nxt    = use_r + CW'(1);
              slot_nxt   = use_r[SW-1:0];
              gen_nxt    = first_gen_gw;
              status_nxt = gha_pkg::ST_OK;
            end else begin
              status_nxt = gha_pkg::ST_EXHAUSTED;
            end
            if (status_nxt == gha_pkg::ST_OK) begin
              sm_we      = 1'b1;
              sm_waddr   = slot_nxt;
              sm_wdata   = {1'b0, 1'b1, gen_nxt};
              live_nxt   = live_r + CW'(1);
              kind_nxt   = pool_kind_r;
              domain_nxt = pool_domain_r;
            end
          end
          gha_pkg::CMD_RELEASE: begin
            if (hit) begin
              sm_we = 1'b1;
              if (row_at_max) begin
                sm_wdata = {1'b1, 1'b0, row_gen};
              end else begin
                sm_wdata = {1'b0, 1'b0, row_gen_inc};
                stk_push = stk_not_full;
              end
              if (live_r != '0) begin
                live_nxt = live_r - CW'(1);
              end
              status_nxt = gha_pkg::ST_OK;
            end
          end
          gha_pkg::CMD_QUERY: begin
            if (hit) begin
              status_nxt = gha_pkg::ST_OK;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r  <= '0;
      live_r <= '0;
    end else begin
      use_r  <= use_nxt;
      live_r <= live_nxt;
    end
  end

  // result register
  logic                       out_valid_r;
  gha_pkg::status_t           out_status_r;
  logic [gha_pkg::KIND_W-1:0] out_kind_r;
  logic [gha_pkg::DOM_W-1:0]  out_domain_r;
  logic [gha_pkg::SLOT_W-1:0] out_slot_r;
  logic [gha_pkg::GEN_W-1:0]  out_gen_r;
  logic [gha_pkg::LIVE_W-1:0] out_live_r;
  logic [31:0]                slot_ext;
  logic [63:0]                gen_ext;
  logic [31:0]                live_ext;

  assign slot_ext = 32'(slot_nxt);
  assign gen_ext  = 64'(gen_nxt);
  assign live_ext = 32'(live_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_status_r <= status_nxt;
      out_kind_r   <= kind_nxt;
      out_domain_r <= domain_nxt;
      out_slot_r   <= slot_ext[gha_pkg::SLOT_W-1:0];
      out_gen_r    <= gen_ext[gha_pkg::GEN_W-1:0];
      out_live_r   <= live_ext[gha_pkg::LIVE_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_new_kind       = out_kind_r;
  assign out_new_domain     = out_domain_r;
  assign out_new_slot       = out_slot_r;
  assign out_new_generation = out_gen_r;
  assign out_live_total     = out_live_r;

endmodule
